@@ design/bule_pkg.sv @@
// Shared types and operation codes for the bounded list engine.
package bule_pkg;

  localparam int ModeW  = 3;
  localparam int IdW    = 16;
  localparam int PayW   = 32;
  localparam int PosW   = 4;
  localparam int CountW = 5;
  localparam int CapW   = 5;

  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

  localparam logic [ModeW-1:0] MODE_INS_FRONT = 3'd0;
  localparam logic [ModeW-1:0] MODE_INS_BACK  = 3'd1;
  localparam logic [ModeW-1:0] MODE_REM_FIRST = 3'd2;
  localparam logic [ModeW-1:0] MODE_REM_LAST  = 3'd3;
  localparam logic [ModeW-1:0] MODE_REM_ID    = 3'd4;
  localparam logic [ModeW-1:0] MODE_FIND_ID   = 3'd5;
  localparam logic [ModeW-1:0] MODE_REPL_ID   = 3'd6;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdW-1:0]   search_id;
    logic [IdW-1:0]   new_id;
    logic [PayW-1:0]  new_payload;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic match;
    logic apply;
  } cmd_t;

endpackage

@@ design/bule_ctrl.sv @@
// Controller state machine: sequences load, match and apply, owns result valid.
module bule_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bule_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_APPLY) && out_free);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load  = in_valid && in_ready;
    cmd.match = (state_r == S_MATCH);
    cmd.apply = (state_r == S_APPLY) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        // hold until the result slot frees up
        if (out_free) state_nxt = cmd.load ? S_MATCH : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/bule_dp.sv @@
// Datapath: entry registers, count, capacity, parallel id compare and shift network.
module bule_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bule_pkg::cmd_t              cmd,
  input  bule_pkg::in_item_t          in_data,
  input  logic                        cfg_we,
  input  logic [bule_pkg::CapW-1:0]   cfg_data,
  output bule_pkg::out_item_t         out_data
);

  localparam int N   = MAX_ENTRIES;
  localparam int CW  = $clog2(N + 1);
  localparam int IW  = (N > 1) ? $clog2(N) : 1;
  localparam int HW  = (IW > bule_pkg::PosW) ? IW : bule_pkg::PosW;
  localparam int CXW = (CW > bule_pkg::CountW) ? CW : bule_pkg::CountW;

  bule_pkg::in_item_t         item_r;
  bule_pkg::out_item_t        out_r, out_nxt;
  logic [bule_pkg::IdW-1:0]   ids_r  [N];
  logic [bule_pkg::IdW-1:0]   ids_nxt [N];
  logic [bule_pkg::PayW-1:0]  pays_r [N];
  logic [bule_pkg::PayW-1:0]  pays_nxt [N];
  logic [CW-1:0]              count_r, count_nxt;
  logic [bule_pkg::CapW-1:0]  cap_r;
  logic [N-1:0]               match_nxt, match_r;
  logic [N-1:0]               ge, first_hot;
  logic [HW-1:0]              hit_idx;
  logic                       hit;
  logic [CXW-1:0]             cap_ext, lim, cnt_ext;
  logic                       can_ins, not_empty;

  // Compare every live entry against the search id.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_nxt[i] = (count_r > CW'(i)) && (ids_r[i] == item_r.search_id);
    end
  end

  // Pick the lowest match; ge marks positions at or above it.
  always_comb begin
    logic run;
    logic prev;
    run     = 1'b0;
    prev    = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      run          = run | match_r[i];
      ge[i]        = run;
      first_hot[i] = match_r[i] & ~prev;
      prev         = run;
      if (first_hot[i]) hit_idx = hit_idx | HW'(i);
    end
    hit = run;
  end

  always_comb begin
    cap_ext   = CXW'(cap_r);
    lim       = (cap_ext < CXW'(N)) ? cap_ext : CXW'(N);
    cnt_ext   = CXW'(count_r);
    can_ins   = cnt_ext < lim;
    not_empty = (count_r != '0);
  end

  always_comb begin
    logic ok;
    logic [HW-1:0] pos;
    ok        = 1'b0;
    pos       = '0;
    count_nxt = count_r;
    for (int i = 0; i < N; i++) begin
      ids_nxt[i]  = ids_r[i];
      pays_nxt[i] = pays_r[i];
    end
    unique case (item_r.mode)
      bule_pkg::MODE_INS_FRONT: begin
        if (can_ins) begin
          ok        = 1'b1;
          count_nxt = count_r + 1'b1;
          for (int i = 0; i < N; i++) begin
            if (i == 0) begin
              ids_nxt[i]  = item_r.new_id;
              pays_nxt[i] = item_r.new_payload;
            end else begin
              ids_nxt[i]  = ids_r[(i == 0) ? 0 : i - 1];
              pays_nxt[i] = pays_r[(i == 0) ? 0 : i - 1];
            end
          end
        end
      end
      bule_pkg::MODE_INS_BACK: begin
        if (can_ins) begin
          ok        = 1'b1;
          count_nxt = count_r + 1'b1;
          for (int i = 0; i < N; i++) begin
            if (CW'(i) == count_r) begin
              ids_nxt[i]  = item_r.new_id;
              pays_nxt[i] = item_r.new_payload;
            end
          end
        end
      end
      bule_pkg::MODE_REM_FIRST: begin
        if (not_empty) begin
          ok        = 1'b1;
          count_nxt = count_r - 1'b1;
          for (int i = 0; i < N - 1; i++) begin
            ids_nxt[i]  = ids_r[(i < N - 1) ? i + 1 : i];
            pays_nxt[i] = pays_r[(i < N - 1) ? i + 1 : i];
          end
        end
      end
      bule_pkg::MODE_REM_LAST: begin
        if (not_empty) begin
          ok        = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      bule_pkg::MODE_REM_ID: begin
        if (hit) begin
          ok        = 1'b1;
          count_nxt = count_r - 1'b1;
          // close the gap from the first match upward
          for (int i = 0; i < N - 1; i++) begin
            if (ge[i]) begin
              ids_nxt[i]  = ids_r[(i < N - 1) ? i + 1 : i];
              pays_nxt[i] = pays_r[(i < N - 1) ? i + 1 : i];
            end
          end
        end
      end
      bule_pkg::MODE_FIND_ID: begin
        if (hit) begin
          ok  = 1'b1;
          pos = hit_idx;
        end
      end
      bule_pkg::MODE_REPL_ID: begin
        if (hit) begin
          ok = 1'b1;
          for (int i = 0; i < N; i++) begin
            if (first_hot[i]) begin
              ids_nxt[i]  = item_r.new_id;
              pays_nxt[i] = item_r.new_payload;
            end
          end
        end
      end
      default: begin
      end
    endcase
    out_nxt.ok       = ok;
    out_nxt.position = pos[bule_pkg::PosW-1:0];
    out_nxt.count    = bule_pkg::CountW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= bule_pkg::CAP_RESET;
    end else begin
      if (cmd.apply) count_r <= count_nxt;
      if (cfg_we)    cap_r   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)  item_r  <= in_data;
    if (cmd.match) match_r <= match_nxt;
    if (cmd.apply) begin
      ids_r  <= ids_nxt;
      pays_r <= pays_nxt;
      out_r  <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

@@ design/bounded_unordered_list_engine.sv @@
// Top level of the bounded list engine: controller, datapath and assertions.
// Ordered list of up to MAX_ENTRIES (id, payload) entries driven by seven operations
// (insert front/back, remove first/last/by id, find by id, replace by id); each item
// returns one result with ok, the find position and the entry count afterward.
// An item passes through the compare state, which checks every live entry with search_id in
// parallel into a registered match vector, and then the apply state, which picks the lowest
// match and applies the shift or write across the entry registers. The next item is
// taken in the apply state, overlapping the last item's apply, while results
// are taken; a result left waiting holds the apply step. capacity_limit is written
// through the cfg port (resets to 16, saturates at MAX_ENTRIES); cfg_ready is always
// high. Entries need no clearing after reset.
module bounded_unordered_list_engine #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bule_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bule_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bule_pkg::CapW-1:0] cfg_data
);

  bule_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  bule_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bule_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // A failed operation never reports a position.
  a_fail_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> (out_data.position == '0))
    else $error("failed result carries a nonzero position");

  // An accepted item goes through its compare cycle with the input closed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened during the compare cycle");

  // A new result appears only after a compare or apply cycle.
  a_result_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.match) || $past(cmd.apply))
    else $error("result raised without a preceding compare");
`endif

endmodule

@@ tb/bule_list_checker.sv @@
// Result checker for the bounded list engine: tracks the list and compares every result.
`timescale 1ns / 100ps

module bule_list_checker #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  bule_pkg::in_item_t        in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  bule_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [bule_pkg::CapW-1:0] cfg_data,
  output int                        fail_count,
  output int                        outstanding
);

  logic [bule_pkg::IdW-1:0]  list_ids  [DEPTH];
  logic [bule_pkg::PayW-1:0] list_pays [DEPTH];
  int unsigned               list_len;
  logic [bule_pkg::CapW-1:0] cap_limit;

  bule_pkg::out_item_t expected_results [$];
  bule_pkg::out_item_t want;

  // Drop the entry at pos and move the ones above it down.
  function automatic void close_gap(int unsigned pos);
    for (int unsigned i = pos + 1; i < list_len; i++) begin
      list_ids[i-1]  = list_ids[i];
      list_pays[i-1] = list_pays[i];
    end
    list_len--;
  endfunction

  // Apply one operation to the tracked list and return the result it must give.
  function automatic bule_pkg::out_item_t apply_list_op(bule_pkg::in_item_t op);
    bule_pkg::out_item_t res;
    int unsigned         lim;
    int                  hit;
    res = '0;
    lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
    hit = -1;
    for (int i = 0; i < int'(list_len); i++) begin
      if (hit < 0 && list_ids[i] == op.search_id) hit = i;
    end
    case (op.mode)
      bule_pkg::MODE_INS_FRONT: begin
        if (list_len < lim) begin
          for (int unsigned i = list_len; i > 0; i--) begin
            list_ids[i]  = list_ids[i-1];
            list_pays[i] = list_pays[i-1];
          end
          list_ids[0]  = op.new_id;
          list_pays[0] = op.new_payload;
          list_len++;
          res.ok = 1'b1;
        end
      end
      bule_pkg::MODE_INS_BACK: begin
        if (list_len < lim) begin
          list_ids[list_len]  = op.new_id;
          list_pays[list_len] = op.new_payload;
          list_len++;
          res.ok = 1'b1;
        end
      end
      bule_pkg::MODE_REM_FIRST: begin
        if (list_len > 0) begin
          close_gap(0);
          res.ok = 1'b1;
        end
      end
      bule_pkg::MODE_REM_LAST: begin
        if (list_len > 0) begin
          list_len--;
          res.ok = 1'b1;
        end
      end
      bule_pkg::MODE_REM_ID: begin
        if (hit >= 0) begin
          close_gap(hit);
          res.ok = 1'b1;
        end
      end
      bule_pkg::MODE_FIND_ID: begin
        if (hit >= 0) begin
          res.position = bule_pkg::PosW'(hit);
          res.ok       = 1'b1;
        end
      end
      bule_pkg::MODE_REPL_ID: begin
        if (hit >= 0) begin
          list_ids[hit]  = op.new_id;
          list_pays[hit] = op.new_payload;
          res.ok         = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = bule_pkg::CountW'(list_len);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len   = 0;
      cap_limit  = bule_pkg::CAP_RESET;
      fail_count = 0;
      expected_results.delete();
    end else begin
      // Retire the result before queuing a new item, so an item never meets its own result.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with no item pending: ok %0b pos %0d count %0d",
                     $realtime, out_data.ok, out_data.position, out_data.count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.ok !== want.ok || out_data.position !== want.position ||
              out_data.count !== want.count) begin
            if (fail_count < 10)
              $display({"%0t: mismatch: expected ok %0b pos %0d count %0d, ",
                        "got ok %0b pos %0d count %0d"},
                       $realtime, want.ok, want.position, want.count,
                       out_data.ok, out_data.position, out_data.count);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) cap_limit = cfg_data;
      if (in_valid && in_ready) expected_results.push_back(apply_list_op(in_data));
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ tb/tb_bounded_unordered_list_engine.sv @@
// Testbench top for the bounded list engine: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_bounded_unordered_list_engine;

  localparam logic [bule_pkg::ModeW-1:0] MODE_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int BLOCKS      = 12;
  localparam int BLOCK_ITEMS = 80;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  bule_pkg::in_item_t        in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  bule_pkg::out_item_t       out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [bule_pkg::CapW-1:0] cfg_data  = '0;

  int fail_count;
  int outstanding;
  int cycle_count   = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 68;

  logic [bule_pkg::IdW-1:0]  id_pool [8];
  logic [bule_pkg::CapW-1:0] cap_plan [BLOCKS];
  int                        bias_left;
  bit                        insert_heavy;

  bounded_unordered_list_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bule_list_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_bounded_unordered_list_engine failed");
      $finish;
    end
  end

  function automatic bule_pkg::in_item_t list_op(logic [bule_pkg::ModeW-1:0] mode,
                                                 logic [bule_pkg::IdW-1:0] sid,
                                                 logic [bule_pkg::IdW-1:0] nid,
                                                 logic [bule_pkg::PayW-1:0] pay);
    bule_pkg::in_item_t it;
    it.mode        = mode;
    it.search_id   = sid;
    it.new_id      = nid;
    it.new_payload = pay;
    return it;
  endfunction

  // Mostly ids from a small pool so that searches hit and duplicates form.
  function automatic logic [bule_pkg::IdW-1:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(7)];
    return bule_pkg::IdW'($urandom_range(65535));
  endfunction

  function automatic bule_pkg::in_item_t draw_list_op(bit grow);
    int                          r;
    logic [bule_pkg::ModeW-1:0] mode;
    r = $urandom_range(99);
    if (r < 2)                    mode = MODE_UNUSED;
    else if (r < (grow ? 37 : 12)) mode = bule_pkg::MODE_INS_FRONT;
    else if (r < (grow ? 72 : 22)) mode = bule_pkg::MODE_INS_BACK;
    else if (r < (grow ? 78 : 40)) mode = bule_pkg::MODE_REM_FIRST;
    else if (r < (grow ? 84 : 55)) mode = bule_pkg::MODE_REM_LAST;
    else if (r < (grow ? 88 : 75)) mode = bule_pkg::MODE_REM_ID;
    else if (r < (grow ? 94 : 88)) mode = bule_pkg::MODE_FIND_ID;
    else                           mode = bule_pkg::MODE_REPL_ID;
    return list_op(mode, pick_id(), pick_id(), $urandom);
  endfunction

  task automatic send_item(input bule_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off new items until every pending result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [bule_pkg::CapW-1:0] cap);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    id_pool  = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                 bule_pkg::IdW'($urandom), bule_pkg::IdW'($urandom),
                 bule_pkg::IdW'($urandom), bule_pkg::IdW'($urandom)};
    cap_plan = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, bule_pkg::CapW'($urandom_range(2, 15)),
                 5'd16, 5'd8, 5'd31, 5'd3, bule_pkg::CapW'($urandom_range(2, 15)), 5'd16};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every removal and search fails; the unused mode does nothing.
    send_item(list_op(bule_pkg::MODE_REM_FIRST, 16'h0000, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_REM_LAST,  16'h0000, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_REM_ID,    16'h0000, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_FIND_ID,   16'hFFFF, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_REPL_ID,   16'h0000, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(list_op(MODE_UNUSED,              16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    // Build a list with a duplicate id, then search, replace the first copy and remove the second.
    send_item(list_op(bule_pkg::MODE_INS_FRONT, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(list_op(bule_pkg::MODE_INS_BACK,  16'hFFFF, 16'h0000, 32'h0000_0000));
    send_item(list_op(bule_pkg::MODE_INS_FRONT, 16'h0000, 16'h1234, 32'h89AB_CDEF));
    send_item(list_op(bule_pkg::MODE_INS_BACK,  16'h0000, 16'hFFFF, 32'h0123_4567));
    send_item(list_op(bule_pkg::MODE_FIND_ID,   16'hFFFF, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_REPL_ID,   16'hFFFF, 16'hA5A5, 32'h5A5A_5A5A));
    send_item(list_op(bule_pkg::MODE_FIND_ID,   16'hFFFF, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_REM_ID,    16'hFFFF, 16'h0000, 32'h0));
    // Absent id: no change; then remove the last and first entries.
    send_item(list_op(bule_pkg::MODE_FIND_ID,   16'h7777, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_REM_ID,    16'h7777, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_REPL_ID,   16'h7777, 16'h4321, 32'h1));
    send_item(list_op(bule_pkg::MODE_REM_LAST,  16'h0000, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_REM_FIRST, 16'h0000, 16'h0000, 32'h0));
    // Small limit: fill it, then lower it below the count.
    set_capacity(5'd2);
    send_item(list_op(bule_pkg::MODE_INS_BACK,  16'h0000, 16'h00FF, 32'hF0F0_F0F0));
    send_item(list_op(bule_pkg::MODE_INS_FRONT, 16'h0000, 16'hFF00, 32'h0F0F_0F0F));
    set_capacity(5'd1);
    send_item(list_op(bule_pkg::MODE_INS_BACK,  16'h0000, 16'h0002, 32'h2));
    send_item(list_op(bule_pkg::MODE_REM_LAST,  16'h0000, 16'h0000, 32'h0));
    send_item(list_op(bule_pkg::MODE_INS_FRONT, 16'h0000, 16'h0003, 32'h3));
    set_capacity(5'd0);
    send_item(list_op(bule_pkg::MODE_INS_BACK,  16'h0000, 16'h0004, 32'h4));

    bias_left    = 0;
    insert_heavy = 1'b0;
    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk < 4) begin
        send_idle_pct = 9;
        recv_idle_pct = 68;
      end else if (blk < 8) begin
        send_idle_pct = 68;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_capacity(cap_plan[blk]);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        // Alternate growing and shrinking runs so the list reaches full and empty.
        if (bias_left == 0) begin
          insert_heavy = !insert_heavy;
          bias_left    = $urandom_range(8, 40);
        end
        bias_left--;
        if ($urandom_range(99) < 3) id_pool[$urandom_range(7)] = bule_pkg::IdW'($urandom);
        send_item(draw_list_op(insert_heavy));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tb_bounded_unordered_list_engine passed");
    else
      $display("tb_bounded_unordered_list_engine failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/bule_pkg.sv
design/bule_ctrl.sv
design/bule_dp.sv
design/bounded_unordered_list_engine.sv
tb/bule_list_checker.sv
tb/tb_bounded_unordered_list_engine.sv
